### rtl/core/page_layout_framebuffer_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page layout frame buffer engine
// Clocked, reset-qualified concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef PAGE_LAYOUT_FRAMEBUFFER_ENGINE_ASSERT_SVH
`define PAGE_LAYOUT_FRAMEBUFFER_ENGINE_ASSERT_SVH

// explicit clock and reset
`define PFB_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// block clock and reset
`define PFB_ASSERT(lbl, prop, msg) `PFB_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

### rtl/core/pfb_pkg.sv
// ----------------------------------------------------------------------------
// Frame buffer engine package
// Shared types, request codes and default geometry.
// ----------------------------------------------------------------------------
package pfb_pkg;

   localparam int DEF_FRAME_WIDTH  = 128;
   localparam int DEF_FRAME_HEIGHT = 64;
   localparam int DEF_FRAME_BYTES  = 1024;

   localparam int KIND_W     = 3;
   localparam int LINE_ROWS  = 16;
   localparam int PAGE_SHIFT = 3;
   localparam int CALC_W     = 24;

   localparam logic [7:0] BYTE_ONES = 8'hFF;

   typedef logic [7:0] byte_type;
   typedef logic signed [CALC_W-1:0] calc_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PIXEL = 3'd0,
      KIND_FILL  = 3'd1,
      KIND_GLYPH = 3'd2,
      KIND_CLEAR = 3'd3,
      KIND_READ  = 3'd4
   } kind_type;

endpackage

### rtl/core/pfb_store.sv
// ----------------------------------------------------------------------------
// Frame byte store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfb_store #(
   parameter int DEPTH = pfb_pkg::DEF_FRAME_BYTES,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  pfb_pkg::byte_type wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output pfb_pkg::byte_type rd_data
);
   import pfb_pkg::*;

   byte_type mem [DEPTH];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/page_layout_framebuffer_engine.sv
// ----------------------------------------------------------------------------
// Page layout frame buffer engine
// Monochrome frame store, 8 rows per byte, with pixel, span fill, glyph
// column, clear and byte readout requests.
//
// channel   | ports                          | handshake
// ----------+--------------------------------+------------------------------
// request   | req_*                          | start && !busy
// response  | rsp_read_data, rsp_accepted    | rsp_valid, one cycle
//
// A rejected request ends at decode; pixel and read requests read a byte,
// a pixel writes it back, a glyph column modifies the upper then the lower
// byte, a fill writes both bytes per span column, a clear sweeps the store;
// the single store write port sets this order. After reset the store is
// swept to zero, busy high. The response strobe rises as busy falls and
// lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module page_layout_framebuffer_engine #(
   parameter int FRAME_WIDTH  = pfb_pkg::DEF_FRAME_WIDTH,
   parameter int FRAME_HEIGHT = pfb_pkg::DEF_FRAME_HEIGHT,
   parameter int FRAME_BYTES  = pfb_pkg::DEF_FRAME_BYTES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [pfb_pkg::KIND_W-1:0] req_kind,
   input  logic signed [10:0]         req_pos_x,
   input  logic signed [10:0]         req_pos_y,
   input  logic signed [7:0]          req_text_line,
   input  logic [7:0]                 req_span_length,
   input  logic                       req_color,
   input  logic [15:0]                req_glyph_column,
   input  logic [7:0]                 req_column_index,
   input  logic [7:0]                 req_glyph_cols,
   input  logic [9:0]                 req_read_index,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_read_data,
   output logic                       rsp_accepted
);
   import pfb_pkg::*;

   localparam int ADDR_W = $clog2(FRAME_BYTES);
   localparam int LINES  = FRAME_HEIGHT / LINE_ROWS;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_BYTES - 1);

   localparam calc_type W_C     = calc_type'(FRAME_WIDTH);
   localparam calc_type H_C     = calc_type'(FRAME_HEIGHT);
   localparam calc_type BYTES_C = calc_type'(FRAME_BYTES);
   localparam calc_type LINES_C = calc_type'(LINES);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_MOD_UP,
      ST_MOD_LO,
      ST_FILL_UP,
      ST_FILL_LO
   } state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic              clr_rsp_ff;
   logic [7:0]        cnt_ff;
   logic              rsp_valid_ff;
   byte_type          rsp_data_ff;
   logic              rsp_ok_ff;

   logic [KIND_W-1:0] kind_ff;
   logic signed [10:0] pos_x_ff;
   logic signed [10:0] pos_y_ff;
   logic signed [7:0] line_ff;
   logic [7:0]        len_ff;
   logic              color_ff;
   logic [15:0]       glyph_ff;
   logic [7:0]        idx_ff;
   logic [7:0]        width_ff;
   logic [9:0]        ridx_ff;

   logic [ADDR_W-1:0] up_ff;
   logic [ADDR_W-1:0] up_in;
   logic [ADDR_W-1:0] lo_ff;
   logic [ADDR_W-1:0] lo_in;

   calc_type x_c, y_c, line_c, len_c, col_c, row_c, base_c, up_c, lo_c;
   logic     line_ok, px_ok, gl_ok, fl_ok, rd_ok;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   byte_type          mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   byte_type          mem_rdata;
   byte_type          px_mask;
   byte_type          px_byte;
   byte_type          fill_byte;

   assign busy = (state_ff != ST_IDLE);

   // latch request beat
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         kind_ff  <= req_kind;
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         line_ff  <= req_text_line;
         len_ff   <= req_span_length;
         color_ff <= req_color;
         glyph_ff <= req_glyph_column;
         idx_ff   <= req_column_index;
         width_ff <= req_glyph_cols;
         ridx_ff  <= req_read_index;
      end
   end

   // address unit: row times width plus column
   always_comb begin
      x_c    = calc_type'(pos_x_ff);
      y_c    = calc_type'(pos_y_ff);
      line_c = calc_type'(line_ff);
      len_c  = calc_type'(len_ff);
      col_c  = (kind_ff == KIND_GLYPH) ? x_c + calc_type'(idx_ff) : x_c;
      row_c  = (kind_ff == KIND_PIXEL) ? (y_c >>> PAGE_SHIFT) : (line_c <<< 1);
      base_c = row_c * W_C;
      up_c   = base_c + col_c;
      lo_c   = up_c + W_C;

      line_ok = (line_c >= 0) && (line_c < LINES_C);
      px_ok   = (x_c >= 0) && (x_c < W_C) && (y_c >= 0) && (y_c < H_C) && (up_c < BYTES_C);
      gl_ok   = (idx_ff < width_ff) && line_ok && (col_c >= 0) && (col_c < W_C)
                && (lo_c < BYTES_C);
      fl_ok   = (x_c >= 0) && (x_c + len_c <= W_C) && line_ok
                && ((len_ff == 8'd0) || (lo_c + len_c - 1 < BYTES_C));
      rd_ok   = calc_type'(ridx_ff) < BYTES_C;

      up_in = (kind_ff == KIND_READ) ? ADDR_W'(ridx_ff) : ADDR_W'(up_c);
      lo_in = ADDR_W'(lo_c);
   end

   // hold and advance store addresses
   always_ff @(posedge clock) begin
      if (state_ff == ST_DECODE) begin
         up_ff <= up_in;
         lo_ff <= lo_in;
      end else if (state_ff == ST_FILL_LO) begin
         up_ff <= up_ff + ADDR_W'(1);
         lo_ff <= lo_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      px_mask   = 8'b1 << pos_y_ff[2:0];
      px_byte   = color_ff ? (mem_rdata | px_mask) : (mem_rdata & ~px_mask);
      fill_byte = color_ff ? BYTE_ONES : 8'h00;
      mem_raddr = (state_ff == ST_MOD_UP) ? lo_ff : up_ff;
      mem_we    = 1'b0;
      mem_waddr = up_ff;
      mem_wdata = fill_byte;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = 8'h00;
         end
         ST_MOD_UP: begin
            mem_we    = (kind_ff != KIND_READ);
            mem_wdata = (kind_ff == KIND_GLYPH) ? (mem_rdata ^ glyph_ff[7:0]) : px_byte;
         end
         ST_MOD_LO: begin
            mem_we    = 1'b1;
            mem_waddr = lo_ff;
            mem_wdata = mem_rdata ^ glyph_ff[15:8];
         end
         ST_FILL_UP: begin
            mem_we = 1'b1;
         end
         ST_FILL_LO: begin
            mem_we    = 1'b1;
            mem_waddr = lo_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   pfb_store #(
      .DEPTH  (FRAME_BYTES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
         rsp_ok_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
               if (clr_addr_ff == LAST_ADDR) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= clr_rsp_ff;
                  rsp_data_ff  <= '0;
                  rsp_ok_ff    <= 1'b1;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               rsp_data_ff <= '0;
               unique case (kind_ff)
                  KIND_PIXEL: begin
                     state_ff     <= px_ok ? ST_READ : ST_IDLE;
                     rsp_valid_ff <= !px_ok;
                     rsp_ok_ff    <= 1'b0;
                  end
                  KIND_GLYPH: begin
                     state_ff     <= gl_ok ? ST_READ : ST_IDLE;
                     rsp_valid_ff <= !gl_ok;
                     rsp_ok_ff    <= 1'b0;
                  end
                  KIND_READ: begin
                     state_ff     <= rd_ok ? ST_READ : ST_IDLE;
                     rsp_valid_ff <= !rd_ok;
                     rsp_ok_ff    <= 1'b0;
                  end
                  KIND_FILL: begin
                     cnt_ff <= len_ff;
                     if (fl_ok && (len_ff != 8'd0)) begin
                        state_ff <= ST_FILL_UP;
                     end else begin
                        state_ff     <= ST_IDLE;
                        rsp_valid_ff <= 1'b1;
                        rsp_ok_ff    <= fl_ok;
                     end
                  end
                  KIND_CLEAR: begin
                     state_ff    <= ST_CLEAR;
                     clr_addr_ff <= '0;
                     clr_rsp_ff  <= 1'b1;
                  end
                  default: begin
                     state_ff     <= ST_IDLE;
                     rsp_valid_ff <= 1'b1;
                     rsp_ok_ff    <= 1'b0;
                  end
               endcase
            end
            ST_READ: begin
               state_ff <= ST_MOD_UP;
            end
            ST_MOD_UP: begin
               if (kind_ff == KIND_GLYPH) begin
                  state_ff <= ST_MOD_LO;
               end else begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
                  rsp_ok_ff    <= 1'b1;
                  rsp_data_ff  <= (kind_ff == KIND_READ) ? mem_rdata : 8'h00;
               end
            end
            ST_MOD_LO: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
               rsp_ok_ff    <= 1'b1;
               rsp_data_ff  <= '0;
            end
            ST_FILL_UP: begin
               state_ff <= ST_FILL_LO;
            end
            ST_FILL_LO: begin
               cnt_ff <= cnt_ff - 8'd1;
               if (cnt_ff == 8'd1) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
                  rsp_ok_ff    <= 1'b1;
                  rsp_data_ff  <= '0;
               end else begin
                  state_ff <= ST_FILL_UP;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_accepted  = rsp_ok_ff;

`include "page_layout_framebuffer_engine_assert.svh"

   `PFB_ASSERT(a_rsp_single, rsp_valid |=> !rsp_valid, "response strobe held two cycles")
   `PFB_ASSERT(a_start_busy, (start && !busy) |=> busy, "request beat did not raise busy")
   `PFB_ASSERT(a_reject_zero, (rsp_valid && !rsp_accepted) |-> (rsp_read_data == 8'h00),
      "rejected request returned data")
   `PFB_ASSERT(a_write_busy, mem_we |-> busy, "store written while idle")
   `PFB_ASSERT(a_beat_no_rsp, (start && !busy) |=> !rsp_valid, "response right after beat")

endmodule
